### hdl/rgb_adaptive_mean_threshold_unit_macros.svh
// Assertion macros shared by the adaptive mean threshold design.
`ifndef RGB_ADAPTIVE_MEAN_THRESHOLD_UNIT_MACROS_SVH
`define RGB_ADAPTIVE_MEAN_THRESHOLD_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RAMT_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("ramt: implication failed");

// Next-cycle implication, checked outside reset.
`define RAMT_ASSERT_NXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("ramt: next-cycle implication failed");

`endif

### hdl/ramt_pkg.sv
// Types, constants and helper functions of the adaptive mean threshold unit.
`default_nettype none

package ramt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COL,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } ramt_state_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_MODE        = 3'd4;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int RADIUS_W     = 4;
  localparam int OFFSET_W     = 9;
  localparam int PIX_W        = 8;
  localparam int RGB_W        = 3 * PIX_W;
  localparam int PSUM_W       = 10;
  localparam int DIV_W        = 12;
  localparam int THIRD_MUL    = 683;
  localparam int THIRD_SHIFT  = 11;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;
  localparam logic [RADIUS_W-1:0]     RADIUS_RESET = 4'd1;

  localparam logic [RGB_W-1:0] PIX_WHITE = 24'hFFFFFF;
  localparam logic [RGB_W-1:0] PIX_TEXT  = 24'h010101;

  function automatic logic [PSUM_W-1:0] pix_sum(input logic [RGB_W-1:0] p);
    pix_sum = PSUM_W'(p[7:0]) + PSUM_W'(p[15:8]) + PSUM_W'(p[23:16]);
  endfunction

  // Window element count times three, (2r+1)^2 * 3.
  function automatic logic [DIV_W-1:0] window_divisor(input logic [RADIUS_W-1:0] r);
    logic [DIV_W-1:0] d;
    unique case (r)
      4'd0:    d = 12'd3;
      4'd1:    d = 12'd27;
      4'd2:    d = 12'd75;
      4'd3:    d = 12'd147;
      4'd4:    d = 12'd243;
      4'd5:    d = 12'd363;
      4'd6:    d = 12'd507;
      4'd7:    d = 12'd675;
      4'd8:    d = 12'd867;
      4'd9:    d = 12'd1083;
      4'd10:   d = 12'd1323;
      4'd11:   d = 12'd1587;
      4'd12:   d = 12'd1875;
      4'd13:   d = 12'd2187;
      4'd14:   d = 12'd2523;
      default: d = 12'd2883;
    endcase
    window_divisor = d;
  endfunction

endpackage

`default_nettype wire

### hdl/ramt_cell.sv
// One cell of the column-sum row: holds a column sum and gates it to the window.
`default_nettype none

module ramt_cell #(
  parameter int IDX   = 0,
  parameter int VAL_W = 14,
  parameter int U_W   = 11
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [VAL_W-1:0] din,
  input  logic [U_W-1:0]   u,
  input  logic [U_W-1:0]   width,
  output logic [VAL_W-1:0] dout,
  output logic [VAL_W-1:0] gated
);

  logic in_window;

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

  // The cell holds column u - IDX; it counts only when that column lies in the row.
  assign in_window = (U_W'(IDX) <= u) && ((U_W'(IDX) + width) > u);
  assign gated     = in_window ? dout : '0;

endmodule

`default_nettype wire

### hdl/rgb_adaptive_mean_threshold_unit.sv
// Top level of the adaptive mean threshold unit for RGB raster streams.
`default_nettype none
`include "rgb_adaptive_mean_threshold_unit_macros.svh"

// Pixels enter in raster order; output pixel k leaves with input word k+R*W+R, so the
// host follows each frame with flush words until the word marked frame_end appears.
// A word that yields a thresholded pixel is accepted, updates the column sum, has the
// row of cells scanned one column sum per cycle, passes the threshold multiply and
// then loads the output register. Words that give no result are accepted and update
// the column sum, pass-through words go from acceptance to the output register, and
// flush words that are dropped are only accepted. Column sums are rewritten on the first
// row of every frame, so no clearing pass runs after reset.
// Configuration takes effect at the first word of the next frame.
module rgb_adaptive_mean_threshold_unit
  import ramt_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [PIX_W-1:0]      red_in,
  input  logic [PIX_W-1:0]      green_in,
  input  logic [PIX_W-1:0]      blue_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      red_out,
  output logic [PIX_W-1:0]      green_out,
  output logic [PIX_W-1:0]      blue_out,
  output logic                  frame_end
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int W_W      = $clog2(MAX_WIDTH + 1);
  localparam int H_W      = $clog2(MAX_HEIGHT + 1);
  localparam int OROW_W   = $clog2(MAX_HEIGHT);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int NSLOT    = 2 * MAX_RADIUS + 2;
  localparam int SLOT_W   = $clog2(NSLOT);
  localparam int LS_DEPTH = NSLOT * (2 ** COL_W);
  localparam int CS_DEPTH = 2 ** COL_W;
  localparam int NCELL    = 2 * MAX_RADIUS + 1;
  localparam int IDX_W    = $clog2(NCELL);
  localparam int CS_W     = $clog2(NCELL * 765 + 1);
  localparam int SUM_W    = $clog2(NCELL * NCELL * 765 + 1);
  localparam int U_W      = $clog2(MAX_WIDTH + 2 ** RADIUS_W + 1);
  localparam int PROD_W   = 23;

  // Configuration registers.
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;
  logic [RADIUS_W-1:0]     cfg_r;
  logic [OFFSET_W-1:0]     cfg_c;
  logic                    cfg_text;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w    <= WIDTH_RESET;
      cfg_h    <= HEIGHT_RESET;
      cfg_r    <= RADIUS_RESET;
      cfg_c    <= '0;
      cfg_text <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:      cfg_w    <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT:     cfg_h    <= cfg_data[HEIGHT_REG_W-1:0];
        REG_WINDOW_RADIUS:    cfg_r    <= cfg_data[RADIUS_W-1:0];
        REG_THRESHOLD_OFFSET: cfg_c    <= cfg_data[OFFSET_W-1:0];
        REG_TEXT_MODE:        cfg_text <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Frame settings taken from the registers at the first word of a frame.
  logic [W_W-1:0]      f_w;
  logic [H_W-1:0]      f_h;
  logic                f_byp;

  always_comb begin
    if (cfg_w == '0) begin
      f_w = W_W'(1);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      f_w = W_W'(MAX_WIDTH);
    end else begin
      f_w = W_W'(cfg_w);
    end
    if (cfg_h == '0) begin
      f_h = H_W'(1);
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      f_h = H_W'(MAX_HEIGHT);
    end else begin
      f_h = H_W'(cfg_h);
    end
    f_byp = (cfg_r == '0) || (32'(cfg_r) > MAX_RADIUS) ||
            (32'(cfg_r) > 32'(f_w >> 1)) || (32'(cfg_r) > 32'(f_h >> 1));
  end

  logic [W_W-1:0]             lat_w;
  logic [H_W-1:0]             lat_h;
  logic [RADIUS_W-1:0]        lat_r;
  logic signed [OFFSET_W-1:0] lat_c;
  logic                       lat_text;
  logic                       lat_byp;
  logic [DIV_W-1:0]           lat_div;

  // Position counters.
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [SLOT_W-1:0] in_slot;
  logic [COL_W-1:0]  out_col;
  logic [OROW_W-1:0] out_row;
  logic [SLOT_W-1:0] out_slot;

  ramt_state_t state;
  ramt_state_t state_next;

  logic accept;
  logic pos_zero;
  logic [W_W-1:0]      c_w;
  logic [H_W-1:0]      c_h;
  logic [RADIUS_W-1:0] c_r;
  logic                c_byp;
  logic                is_pix;
  logic                in_frame;
  logic                byp_last;
  logic                produce;
  logic                nb_last;
  logic                take_byp;
  logic                take_nb;
  logic                in_col_wrap;
  logic                out_col_wrap;
  logic [SLOT_W-1:0]   leave_slot;
  logic [RGB_W-1:0]    pix_in;

  assign accept   = in_valid && in_ready;
  assign pos_zero = (in_row == '0) && (in_col == '0);
  assign c_w      = pos_zero ? f_w : lat_w;
  assign c_h      = pos_zero ? f_h : lat_h;
  assign c_r      = pos_zero ? cfg_r : lat_r;
  assign c_byp    = pos_zero ? f_byp : lat_byp;
  assign is_pix   = !req_type;
  assign pix_in   = {blue_in, green_in, red_in};

  always_comb begin
    in_frame     = 32'(in_row) < 32'(c_h);
    byp_last     = (32'(in_row) == 32'(c_h) - 1) && (32'(in_col) == 32'(c_w) - 1);
    produce      = (32'(in_row) > 32'(c_r)) ||
                   ((32'(in_row) == 32'(c_r)) && (32'(in_col) >= 32'(c_r)));
    nb_last      = produce && (32'(out_row) == 32'(c_h) - 1) &&
                   (32'(out_col) == 32'(c_w) - 1);
    take_byp     = c_byp && is_pix;
    take_nb      = !c_byp && (is_pix || !in_frame);
    in_col_wrap  = (32'(in_col) + 1) == 32'(c_w);
    out_col_wrap = (32'(out_col) + 1) == 32'(c_w);
    if (32'(in_slot) >= (2 * 32'(c_r) + 1)) begin
      leave_slot = in_slot - SLOT_W'(2 * 32'(c_r) + 1);
    end else begin
      leave_slot = in_slot + SLOT_W'(NSLOT) - SLOT_W'(2 * 32'(c_r) + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_r   <= RADIUS_RESET;
      lat_byp <= 1'b0;
    end else if (accept && pos_zero) begin
      lat_r   <= cfg_r;
      lat_byp <= f_byp;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos_zero) begin
      lat_w    <= f_w;
      lat_h    <= f_h;
      lat_c    <= cfg_c;
      lat_text <= cfg_text;
      lat_div  <= window_divisor(cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
    end else if (accept) begin
      if ((take_byp && byp_last) || (take_nb && nb_last)) begin
        in_col   <= '0;
        in_row   <= '0;
        in_slot  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_slot <= '0;
      end else begin
        if (take_byp || take_nb) begin
          if (in_col_wrap) begin
            in_col  <= '0;
            in_row  <= in_row + 1'b1;
            in_slot <= (32'(in_slot) == NSLOT - 1) ? '0 : in_slot + 1'b1;
          end else begin
            in_col <= in_col + 1'b1;
          end
        end
        if (take_nb && produce) begin
          if (out_col_wrap) begin
            out_col  <= '0;
            out_row  <= out_row + 1'b1;
            out_slot <= (32'(out_slot) == NSLOT - 1) ? '0 : out_slot + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // Word held while it is worked on.
  logic [COL_W-1:0]  item_col;
  logic [ROW_W-1:0]  item_row;
  logic [COL_W-1:0]  item_out_col;
  logic [RGB_W-1:0]  item_pix;
  logic [PSUM_W-1:0] item_psin;
  logic              item_byp;
  logic              item_last;
  logic              item_produce;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_col     <= in_col;
      item_row     <= in_row;
      item_out_col <= out_col;
      item_pix     <= pix_in;
      item_psin    <= in_frame ? pix_sum(pix_in) : '0;
      item_byp     <= c_byp;
      item_last    <= take_byp ? byp_last : nb_last;
      item_produce <= produce;
    end
  end

  // Pixel ring of 2*MAX_RADIUS+2 rows and the column-sum memory.
  logic [RGB_W-1:0] line_store [LS_DEPTH];
  logic [CS_W-1:0]  column_sums [CS_DEPTH];
  logic [RGB_W-1:0] leave_q;
  logic [RGB_W-1:0] cen_q;
  logic [CS_W-1:0]  cs_q;

  always_ff @(posedge clk) begin
    if (accept && take_nb && in_frame) begin
      line_store[{in_slot, in_col}] <= pix_in;
    end
    if (accept) begin
      leave_q <= line_store[{leave_slot, in_col}];
      cen_q   <= line_store[{out_slot, out_col}];
      cs_q    <= column_sums[in_col];
    end
  end

  // Control.
  logic col_en;
  logic sum_en;
  logic mul_en;
  logic out_load;
  logic [IDX_W-1:0] sum_idx;
  logic             sum_done;

  assign sum_done = 32'(sum_idx) == 2 * 32'(lat_r);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && take_byp) begin
          state_next = ST_OUT;
        end else if (accept && take_nb) begin
          state_next = ST_COL;
        end
      end
      ST_COL:  state_next = item_produce ? ST_SUM : ST_IDLE;
      ST_SUM:  state_next = sum_done ? ST_MUL : ST_SUM;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT:  state_next = (!out_valid || out_ready) ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == ST_IDLE;
    col_en   = state == ST_COL;
    sum_en   = state == ST_SUM;
    mul_en   = state == ST_MUL;
    out_load = (state == ST_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Column sum update: add the entering pixel and drop the one 2R+1 rows up.
  logic [PSUM_W-1:0] leave_ps;
  logic [CS_W-1:0]   cs_base;
  logic [CS_W:0]     cs_sum;
  logic [CS_W-1:0]   cs_new;

  always_comb begin
    leave_ps = (32'(item_row) >= (2 * 32'(lat_r) + 1)) ? pix_sum(leave_q) : '0;
    cs_base  = (item_row == '0) ? '0 : cs_q;
    cs_sum   = (CS_W + 1)'(cs_base) + (CS_W + 1)'(item_psin) - (CS_W + 1)'(leave_ps);
    cs_new   = cs_sum[CS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (col_en) begin
      column_sums[item_col] <= cs_new;
    end
  end

  // Row of cells holding the latest 2*MAX_RADIUS+1 column sums.
  logic [CS_W-1:0] cell_q     [NCELL];
  logic [CS_W-1:0] cell_gated [NCELL];
  logic [U_W-1:0]  win_u;
  logic [U_W-1:0]  win_w;

  assign win_u = U_W'(item_out_col) + U_W'(lat_r);
  assign win_w = U_W'(lat_w);

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    ramt_cell #(
      .IDX   (j),
      .VAL_W (CS_W),
      .U_W   (U_W)
    ) u_cell (
      .clk   (clk),
      .shift (col_en),
      .din   ((j == 0) ? cs_new : cell_q[(j == 0) ? 0 : j - 1]),
      .u     (win_u),
      .width (win_w),
      .dout  (cell_q[j]),
      .gated (cell_gated[j])
    );
  end

  // Window sum, intensity and threshold product.
  logic [SUM_W-1:0]          acc;
  logic [PIX_W-1:0]          inten_q;
  logic [19:0]               third_prod;
  logic signed [PSUM_W-1:0]  thr_x;
  logic signed [PROD_W-1:0]  prod;
  logic                      white;
  logic [RGB_W-1:0]          res;

  assign third_prod = 20'(pix_sum(cen_q)) * 20'(THIRD_MUL);
  assign thr_x      = $signed({2'b00, inten_q}) + PSUM_W'(lat_c);

  always_ff @(posedge clk) begin
    if (col_en) begin
      inten_q <= third_prod[THIRD_SHIFT+PIX_W-1:THIRD_SHIFT];
      acc     <= '0;
      sum_idx <= '0;
    end else if (sum_en) begin
      acc     <= acc + SUM_W'(cell_gated[sum_idx]);
      sum_idx <= sum_idx + 1'b1;
    end
    if (mul_en) begin
      prod <= PROD_W'(thr_x) * $signed({1'b0, lat_div});
    end
  end

  // Intensity exceeds mean minus offset exactly when (intensity + offset) * divisor > sum.
  always_comb begin
    white = !item_byp && ($signed(32'(prod)) > $signed(32'(acc)));
    if (item_byp) begin
      res = item_pix;
    end else if (white) begin
      res = PIX_WHITE;
    end else if (lat_text) begin
      res = PIX_TEXT;
    end else begin
      res = cen_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_out   <= res[7:0];
      green_out <= res[15:8];
      blue_out  <= res[23:16];
      frame_end <= item_last;
    end
  end

  `RAMT_ASSERT_IMP(a_last_resets_position, clk, rst, (state == ST_OUT) && item_last, (in_row == '0) && (in_col == '0) && (out_row == '0) && (out_col == '0))
  `RAMT_ASSERT_IMP(a_radius_valid, clk, rst, !lat_byp, (lat_r != '0) && (32'(lat_r) <= MAX_RADIUS))
  `RAMT_ASSERT_IMP(a_scan_in_window, clk, rst, state == ST_SUM, 32'(sum_idx) <= 2 * 32'(lat_r))

endmodule

`default_nettype wire
